/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL; every check runs on the rising clock edge
// and is held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/psv_pkg.sv */
package psv_pkg;

    // Result codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FORBIDDEN = 3'd3,
        ST_TRAVERSAL = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_ABS_PERMIT   = 1'b0,
        CFG_LENGTH_LIMIT = 1'b1
    } cfg_index_t;

    localparam int CFG_WIDTH = 13;

    // Byte window: the newest byte plus the held history
    localparam int WIN     = 9;
    localparam int HIST    = WIN - 1;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Forbidden substrings; byte k of an entry is the byte expected k places
    // back from the newest byte of the window.
    localparam int NPAT = 7;
    localparam logic [8*WIN-1:0] FORBID_PAT [NPAT] = '{
        72'("/etc/"),
        72'("/proc/"),
        72'("/sys/"),
        72'("/dev/"),
        72'("/root/"),
        72'("~/.ssh/"),
        72'("~/.gnupg/")
    };
    localparam int FORBID_LEN [NPAT] = '{5, 6, 5, 5, 6, 7, 9};

endpackage

/* sv/path_string_validator.sv */
// The byte with tlast passes the input stage; its status then loads the result register and raises m_axis_tvalid.
// Throughput: one byte per cycle; a byte with tlast waits while an untaken status fills the result.
// One status transaction leaves for each input transaction that carries tlast.
// Reset (rst_n, async, active low): clears all scan state, both stages and the
//   configuration (absolute paths refused, length limit 0 selects MAX_LEN).
`include "assert_macros.svh"

module path_string_validator
    import psv_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] ch
    input  logic                 s_axis_tuser,   // [0] has_char
    input  logic                 s_axis_tlast,
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [2:0] status, [7:3] zero
);

    // The count saturates at a cap that is at least every selectable limit,
    // so the length decision stays exact.
    localparam int CAP = (MAX_LEN > 8191) ? MAX_LEN : 8191;
    localparam int CW  = $clog2(CAP + 1);

    // Configuration
    logic                 allow_abs_reg;
    logic [CFG_WIDTH-1:0] length_limit_reg;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       has_reg;
    logic       last_reg;

    // Scan state
    logic [CW-1:0]        count_reg,     count_next,     count_upd;
    logic [8*HIST-1:0]    recent_reg,    recent_next,    recent_upd;
    logic                 first_sl_reg,  first_sl_next,  first_sl_upd;
    logic                 second_co_reg, second_co_next, second_co_upd;
    logic                 dotdot_reg,    dotdot_next,    dotdot_upd;
    logic                 dslash_reg,    dslash_next,    dslash_upd;
    logic                 forbid_reg,    forbid_next,    forbid_upd;
    logic                 control_reg,   control_next,   control_upd;

    // Result stage
    logic    out_valid_reg;
    status_t status_reg;
    status_t status_next;

    logic              advance;
    logic              step;
    logic              finish;
    logic [8*WIN-1:0]  win;
    logic              pat_hit;
    logic [CW-1:0]     limit;

    // ---------------------------------------------------------------
    // Handshake: the input stage moves on whenever it has no last byte
    // or the result register is free (or being drained this cycle).
    // ---------------------------------------------------------------
    assign advance       = in_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign step          = advance && has_reg;
    assign finish        = advance && last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, status_reg};

    // Newest byte at the bottom, history above it
    assign win = {recent_reg, ch_reg};

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_abs_reg    <= 1'b0;
            length_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ABS_PERMIT:   allow_abs_reg    <= cfg_data[0];
                CFG_LENGTH_LIMIT: length_limit_reg <= cfg_data;
                default:          allow_abs_reg    <= allow_abs_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Window compare against the forbidden substrings
    // ---------------------------------------------------------------
    always_comb
    begin
        logic hit;
        pat_hit = 1'b0;
        for (int p = 0; p < NPAT; p++)
        begin
            hit = 1'b1;
            for (int k = 0; k < WIN; k++)
            begin
                if (k < FORBID_LEN[p] && win[8*k +: 8] != FORBID_PAT[p][8*k +: 8])
                    hit = 1'b0;
            end
            pat_hit = pat_hit | hit;
        end
    end

    // ---------------------------------------------------------------
    // State update: fold in the byte, then decide on the updated view
    // ---------------------------------------------------------------
    always_comb
    begin
        count_upd     = count_reg;
        recent_upd    = recent_reg;
        first_sl_upd  = first_sl_reg;
        second_co_upd = second_co_reg;
        dotdot_upd    = dotdot_reg;
        dslash_upd    = dslash_reg;
        forbid_upd    = forbid_reg;
        control_upd   = control_reg;

        if (step)
        begin
            recent_upd = win[8*HIST-1:0];
            if (count_reg == '0 && ch_reg == CH_SLASH)
                first_sl_upd = 1'b1;
            if (count_reg == CW'(1) && ch_reg == CH_COLON)
                second_co_upd = 1'b1;
            if (count_reg != CW'(CAP))
                count_upd = count_reg + CW'(1);
            if (win[7:0] == CH_DOT && win[15:8] == CH_DOT)
                dotdot_upd = 1'b1;
            if (win[7:0] == CH_SLASH && win[15:8] == CH_SLASH)
                dslash_upd = 1'b1;
            if (pat_hit)
                forbid_upd = 1'b1;
            if (ch_reg < PRINT_LO || ch_reg > PRINT_HI)
                control_upd = 1'b1;
        end

        // Drop everything after the last byte so no match spans two strings
        if (finish)
        begin
            count_next     = '0;
            recent_next    = '0;
            first_sl_next  = 1'b0;
            second_co_next = 1'b0;
            dotdot_next    = 1'b0;
            dslash_next    = 1'b0;
            forbid_next    = 1'b0;
            control_next   = 1'b0;
        end
        else
        begin
            count_next     = count_upd;
            recent_next    = recent_upd;
            first_sl_next  = first_sl_upd;
            second_co_next = second_co_upd;
            dotdot_next    = dotdot_upd;
            dslash_next    = dslash_upd;
            forbid_next    = forbid_upd;
            control_next   = control_upd;
        end
    end

    // Zero limit selects the built-in maximum
    assign limit = (length_limit_reg == '0) ? CW'(MAX_LEN) : CW'(length_limit_reg);

    // Priority: length, empty, absolute, "..", "//", forbidden, control
    always_comb
    begin
        if (count_upd >= limit)
            status_next = ST_TOO_LONG;
        else if (count_upd == '0)
            status_next = ST_EMPTY;
        else if (!allow_abs_reg && (first_sl_upd || (second_co_upd && count_upd >= CW'(3))))
            status_next = ST_FORBIDDEN;
        else if (dotdot_upd)
            status_next = ST_TRAVERSAL;
        else if (dslash_upd)
            status_next = ST_INVALID;
        else if (forbid_upd)
            status_next = ST_FORBIDDEN;
        else if (control_upd)
            status_next = ST_INVALID;
        else
            status_next = ST_OK;
    end

    // ---------------------------------------------------------------
    // Input stage
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ch_reg   <= s_axis_tdata;
            has_reg  <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            recent_reg    <= '0;
            first_sl_reg  <= 1'b0;
            second_co_reg <= 1'b0;
            dotdot_reg    <= 1'b0;
            dslash_reg    <= 1'b0;
            forbid_reg    <= 1'b0;
            control_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            recent_reg    <= recent_next;
            first_sl_reg  <= first_sl_next;
            second_co_reg <= second_co_next;
            dotdot_reg    <= dotdot_next;
            dslash_reg    <= dslash_next;
            forbid_reg    <= forbid_next;
            control_reg   <= control_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register: load on the last byte, hold until taken
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= status_next;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_CLK(a_clear_after_last, finish |=> (count_reg == '0 && !forbid_reg), "state kept")
    `ASSERT_CLK(a_valid_after_last, finish |=> out_valid_reg, "status not raised")
    `ASSERT_CLK(a_result_loaded, finish |=> (status_reg == $past(status_next)), "no status")
    `ASSERT_CLK(a_stage_holds, !s_axis_tready |=> $stable({ch_reg, last_reg}), "input lost")
    `ASSERT_NEVER(a_empty_no_bytes, finish && status_next == ST_EMPTY && has_reg, "bad empty")

endmodule
